@@ src/bpr_pkg.sv @@
package bpr_pkg;

  // fixed widths of the item fields and registers
  localparam int ByteW  = 8;
  localparam int LenW   = 4;
  localparam int CfgW   = 64;
  localparam int TotalW = 24;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FIND_BYTES = 2'd0,
    REG_FIND_LEN   = 2'd1,
    REG_REPL_BYTES = 2'd2,
    REG_REPL_LEN   = 2'd3
  } bpr_reg_e;

  // per-cycle control of the window cells
  typedef struct packed {
    logic en;
    logic shift;
    logic drop;
  } bpr_cell_ctl_t;

  // shared fields of one result burst
  typedef struct packed {
    logic              is_end;
    logic              has_byte;
    logic [TotalW-1:0] total;
  } bpr_hdr_t;

endpackage

@@ src/bpr_cell.sv @@
module bpr_cell #(
  parameter int IDX    = 0,
  parameter int FILL_W = 4
) (
  input  logic                  clk_i,
  input  bpr_pkg::bpr_cell_ctl_t ctl_i,
  input  logic [FILL_W-1:0]     fill_i,
  input  logic [FILL_W-1:0]     len_i,
  input  logic [7:0]            new_byte_i,
  input  logic [7:0]            nbr_i,
  input  logic [7:0]            drop_byte_i,
  input  logic [7:0]            pat_i,
  output logic [7:0]            w_q_o,
  output logic [7:0]            w_now_o,
  output logic                  eq_o
);
  import bpr_pkg::*;

  logic [7:0] byte_q, byte_d;

  // the incoming byte lands in the first free cell
  assign w_now_o = (fill_i == FILL_W'(IDX)) ? new_byte_i : byte_q;
  assign w_q_o   = byte_q;

  // cells beyond the pattern length always agree
  assign eq_o = (FILL_W'(IDX) >= len_i) || (w_now_o == pat_i);

  // next content: from the neighbor on a shift, realigned on a drop
  always_comb begin
    if (ctl_i.drop) begin
      byte_d = drop_byte_i;
    end else if (ctl_i.shift) begin
      byte_d = nbr_i;
    end else begin
      byte_d = w_now_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      byte_q <= byte_d;
    end
  end

endmodule

@@ src/bpr_burst.sv @@
module bpr_burst #(
  parameter int DEPTH = 8,
  parameter int CNT_W = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [DEPTH-1:0][7:0]     ld_bytes_i,
  input  logic [CNT_W-1:0]          ld_cnt_i,
  input  bpr_pkg::bpr_hdr_t         ld_hdr_i,
  input  logic                      res_stall_i,
  output logic                      res_valid_o,
  output logic [7:0]                out_byte_o,
  output logic                      out_valid_o,
  output logic                      run_last_o,
  output logic                      stream_done_o,
  output logic [bpr_pkg::TotalW-1:0] match_total_o,
  output logic                      in_stall_o
);
  import bpr_pkg::*;

  logic [DEPTH-1:0][7:0] byte_q, byte_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  bpr_hdr_t              hdr_q;
  logic                  pop;
  logic                  last;

  assign pop  = (cnt_q != '0) && !res_stall_i;
  assign last = (cnt_q == CNT_W'(1));

  // a new item may load once at most one result is left and it leaves now
  assign in_stall_o = (cnt_q > CNT_W'(1)) || (last && res_stall_i);

  // result outputs from the head of the buffer
  assign res_valid_o   = (cnt_q != '0);
  assign out_byte_o    = byte_q[0];
  assign out_valid_o   = hdr_q.has_byte;
  assign run_last_o    = last;
  assign stream_done_o = last && hdr_q.is_end;
  assign match_total_o = hdr_q.total;

  // shift toward the head on each delivered item
  always_comb begin
    for (int j = 0; j < DEPTH - 1; j++) begin
      byte_d[j] = byte_q[j+1];
    end
    byte_d[DEPTH-1] = 8'h00;
    cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= ld_cnt_i;
    end else if (pop) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q <= ld_bytes_i;
      hdr_q  <= ld_hdr_i;
    end else if (pop) begin
      byte_q <= byte_d;
    end
  end

endmodule

@@ src/byte_pattern_replacer.sv @@
// Streaming search and replace on a byte stream. Each source byte enters a
// row of window cells, one per pattern byte, that compare in place against
// the pattern; a full window that matches emits the replacement and clears,
// otherwise the oldest byte leaves and the row shifts by one. The byte marked
// end_of_stream flushes the window and the last result carries stream_done
// and the saturating replacement count. Results leave one per cycle from a
// burst buffer unless stalled; a byte causing zero or one result is taken
// every cycle, one causing n results (replacement or end flush, n up to eight)
// holds the input while the buffer drains. The user writes configuration
// only while idle, not enforced by the block. Shortening the pattern drops the
// oldest surplus window bytes. No clearing pass is needed after reset.
module byte_pattern_replacer #(
  parameter int MAX_FIND_BYTES    = 8,
  parameter int MAX_REPLACE_BYTES = 8,
  parameter int COUNT_BITS        = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [bpr_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        end_of_stream_i,
  output logic                        res_valid_o,
  input  logic                        res_stall_i,
  output logic [7:0]                  out_byte_o,
  output logic                        out_valid_o,
  output logic                        run_last_o,
  output logic                        stream_done_o,
  output logic [bpr_pkg::TotalW-1:0]  match_total_o
);
  import bpr_pkg::*;

  localparam int FillW  = $clog2(MAX_FIND_BYTES + 1);
  localparam int BurstD = (MAX_FIND_BYTES > MAX_REPLACE_BYTES) ?
                          MAX_FIND_BYTES : MAX_REPLACE_BYTES;
  localparam int CntW   = $clog2(BurstD + 1);

  // configuration registers
  logic [CfgW-1:0] find_q, rep_q;
  logic [LenW-1:0] flen_q, rlen_q;

  // stream state
  logic [FillW-1:0]      fill_q, fill_d;
  logic [COUNT_BITS-1:0] match_q, match_inc;

  logic                  in_acc;
  logic [FillW-1:0]      len_eff, len_new, fill_now, drop_k;
  logic [CntW-1:0]       rl_eff, ld_cnt;
  logic                  full, hit, marker, drop_cfg;
  logic [31:0]           total_ext;
  bpr_cell_ctl_t         cell_ctl;
  bpr_hdr_t              ld_hdr;

  logic [MAX_FIND_BYTES-1:0][7:0] w_q, w_now, drop_byte;
  logic [MAX_FIND_BYTES-1:0]      eq;
  logic [BurstD-1:0][7:0]         ld_bytes;

  assign in_acc = in_valid_i && !in_stall_o;

  // effective lengths, clamped into range
  always_comb begin
    if (flen_q == '0) begin
      len_eff = FillW'(1);
    end else if (flen_q > LenW'(MAX_FIND_BYTES)) begin
      len_eff = FillW'(MAX_FIND_BYTES);
    end else begin
      len_eff = FillW'(flen_q);
    end
    if (cfg_data_i[LenW-1:0] == '0) begin
      len_new = FillW'(1);
    end else if (cfg_data_i[LenW-1:0] > LenW'(MAX_FIND_BYTES)) begin
      len_new = FillW'(MAX_FIND_BYTES);
    end else begin
      len_new = FillW'(cfg_data_i[LenW-1:0]);
    end
    if (rlen_q > LenW'(MAX_REPLACE_BYTES)) begin
      rl_eff = CntW'(MAX_REPLACE_BYTES);
    end else begin
      rl_eff = CntW'(rlen_q);
    end
  end

  // window status after the incoming byte is placed
  assign fill_now = fill_q + FillW'(1);
  assign full     = (fill_now >= len_eff);
  assign hit      = full && (&eq);
  assign marker   = hit && end_of_stream_i && (rl_eff == '0);

  // shortening the pattern keeps only the newest len-1 bytes
  assign drop_cfg = cfg_we_i && (bpr_reg_e'(cfg_idx_i) == REG_FIND_LEN) &&
                    (fill_q >= len_new);
  assign drop_k   = fill_q - (len_new - FillW'(1));

  always_comb begin
    for (int i = 0; i < MAX_FIND_BYTES; i++) begin
      drop_byte[i] = 8'h00;
      for (int j = 0; j < MAX_FIND_BYTES; j++) begin
        if (j >= i && FillW'(j - i) == drop_k) begin
          drop_byte[i] = w_q[j];
        end
      end
    end
  end

  assign cell_ctl.en    = in_acc || drop_cfg;
  assign cell_ctl.shift = full && !hit;
  assign cell_ctl.drop  = drop_cfg;

  // row of window cells
  for (genvar i = 0; i < MAX_FIND_BYTES; i++) begin : g_cell
    logic [7:0] nbr;
    if (i + 1 < MAX_FIND_BYTES) begin : g_nbr
      assign nbr = w_now[i+1];
    end else begin : g_end
      assign nbr = 8'h00;
    end
    bpr_cell #(
      .IDX    (i),
      .FILL_W (FillW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl),
      .fill_i      (fill_q),
      .len_i       (len_eff),
      .new_byte_i  (data_byte_i),
      .nbr_i       (nbr),
      .drop_byte_i (drop_byte[i]),
      .pat_i       (find_q[8*i +: 8]),
      .w_q_o       (w_q[i]),
      .w_now_o     (w_now[i]),
      .eq_o        (eq[i])
    );
  end

  // burst contents: replacement on a hit, else the window from its oldest byte
  for (genvar j = 0; j < BurstD; j++) begin : g_ld
    logic [7:0] win_b;
    if (j < MAX_FIND_BYTES) begin : g_win
      assign win_b = w_now[j];
    end else begin : g_zero
      assign win_b = 8'h00;
    end
    assign ld_bytes[j] = marker ? 8'h00 : (hit ? rep_q[8*j +: 8] : win_b);
  end

  always_comb begin
    if (marker) begin
      ld_cnt = CntW'(1);
    end else if (hit) begin
      ld_cnt = rl_eff;
    end else if (end_of_stream_i) begin
      ld_cnt = CntW'(fill_now);
    end else if (full) begin
      ld_cnt = CntW'(1);
    end else begin
      ld_cnt = '0;
    end
  end

  // saturating replacement count
  assign match_inc = (match_q == '1) ? match_q : match_q + COUNT_BITS'(1);
  assign total_ext = 32'(hit ? match_inc : match_q);

  assign ld_hdr.is_end   = end_of_stream_i;
  assign ld_hdr.has_byte = !marker;
  assign ld_hdr.total    = total_ext[TotalW-1:0];

  // next fill level
  always_comb begin
    fill_d = fill_q;
    if (drop_cfg) begin
      fill_d = len_new - FillW'(1);
    end else if (in_acc) begin
      if (hit || end_of_stream_i) begin
        fill_d = '0;
      end else if (full) begin
        fill_d = fill_q;
      end else begin
        fill_d = fill_now;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      find_q <= '0;
      flen_q <= LenW'(1);
      rep_q  <= '0;
      rlen_q <= '0;
    end else if (cfg_we_i) begin
      unique case (bpr_reg_e'(cfg_idx_i))
        REG_FIND_BYTES: find_q <= cfg_data_i;
        REG_FIND_LEN:   flen_q <= cfg_data_i[LenW-1:0];
        REG_REPL_BYTES: rep_q  <= cfg_data_i;
        REG_REPL_LEN:   rlen_q <= cfg_data_i[LenW-1:0];
        default:        find_q <= find_q;
      endcase
    end
  end

  // stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      match_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (in_acc) begin
        if (end_of_stream_i) begin
          match_q <= '0;
        end else if (hit) begin
          match_q <= match_inc;
        end
      end
    end
  end

  // result burst buffer
  bpr_burst #(
    .DEPTH (BurstD),
    .CNT_W (CntW)
  ) u_burst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (in_acc),
    .ld_bytes_i    (ld_bytes),
    .ld_cnt_i      (ld_cnt),
    .ld_hdr_i      (ld_hdr),
    .res_stall_i   (res_stall_i),
    .res_valid_o   (res_valid_o),
    .out_byte_o    (out_byte_o),
    .out_valid_o   (out_valid_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o),
    .match_total_o (match_total_o),
    .in_stall_o    (in_stall_o)
  );

`ifndef SYNTHESIS
  // input is held back only while results are pending
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> res_valid_o)
    else $error("input stalled with no result pending");

  // the window never holds a full pattern between items
  a_fill_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < len_eff)
    else $error("window fill reached pattern length");

  // stream end returns window and count to their start values
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_stream_i) |=> (fill_q == '0 && match_q == '0))
    else $error("state not cleared after stream end");

  // a stream end item always yields at least one result
  a_end_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_stream_i) |=> res_valid_o)
    else $error("stream end produced no result");
`endif

endmodule
